### hdl/pa_pkg.sv
// shared types and constants of the page allocator
package pa_pkg;

  localparam int unsigned NUM_PAGES_DEF  = 4096;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PAGE_W   = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 13;

  localparam logic [CFG_W-1:0] TOTAL_RST = 13'd4096;
  localparam logic [CFG_W-1:0] FIRST_RST = 13'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_INC   = 2'd2,
    MODE_DEC   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_TOTAL = 1'b0,
    REG_FIRST = 1'b1
  } reg_e;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ALLOC = 9'b000000100,
    S_PUSH  = 9'b000001000,
    S_RMW   = 9'b000010000,
    S_LINK  = 9'b000100000,
    S_WRD   = 9'b001000000,
    S_WCHK  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

endpackage

### hdl/page_allocator_refcount.sv
// Page allocator with saturating reference counts, a doubly linked free list
// and bottom/top marks. Counts and listed bits sit in one ram, next and prev
// links in two more, all driven by one sequencer. alloc takes the list head,
// or the page just below top when the list is empty; push carves pages up
// from bottom one at a time. A dec_ref to zero links the page into the free
// list, or raises top when the page sits at top, climbing over further
// zero-count pages.
// After reset and after every configuration write a clearing pass rewrites
// the count ram; no request is taken meanwhile.
module page_allocator_refcount #(
  parameter int unsigned NUM_PAGES  = pa_pkg::NUM_PAGES_DEF,
  parameter int unsigned COUNT_BITS = pa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pa_pkg::MODE_W-1:0]     mode_i,
  input  logic [pa_pkg::PAGE_W-1:0]     page_number_i,
  input  logic [pa_pkg::COUNT_W-1:0]    page_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pa_pkg::PAGE_W-1:0]     result_page_o,
  output logic [pa_pkg::STATUS_W-1:0]   status_o,
  output logic [pa_pkg::COUNT_W-1:0]    free_pages_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [pa_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned MW = PW + 1;
  localparam int unsigned CW = COUNT_BITS;
  localparam logic [MW-1:0] NO_LINK = {MW{1'b1}};
  localparam logic [MW-1:0] NP_M    = MW'(NUM_PAGES);
  localparam logic [MW-1:0] LAST_M  = MW'(NUM_PAGES - 1);
  localparam logic [CW-1:0] CMAX    = {CW{1'b1}};

  function automatic logic [MW-1:0] clamp(input logic [pa_pkg::CFG_W-1:0] v);
    logic [31:0] vx;
    vx = 32'(v);
    return (vx > 32'(NUM_PAGES)) ? NP_M : MW'(vx);
  endfunction

  pa_pkg::state_e state_q, state_d;
  logic [pa_pkg::CFG_W-1:0] total_q, first_q;
  logic [MW-1:0] limit_q, top_q, top_d, bottom_q, bottom_d, head_q, head_d;
  logic [MW-1:0] idx_q, idx_d, end_q, end_d;
  pa_pkg::mode_e mode_q, mode_d;
  logic [PW-1:0] page_q, page_d;
  logic [MW-1:0] res_page_q, res_page_d;
  pa_pkg::status_e res_st_q, res_st_d;
  logic out_valid_q;
  logic [pa_pkg::PAGE_W-1:0] out_page_q;
  pa_pkg::status_e out_st_q;
  logic [pa_pkg::COUNT_W-1:0] out_free_q;

  // ram ports
  logic          c_we, c_re, n_we, n_re, p_we, p_re;
  logic [PW-1:0] c_wa, c_ra, n_wa, n_ra, p_wa, p_ra;
  logic [CW:0]   c_wd, c_rd;
  logic [MW-1:0] n_wd, n_rd, p_wd, p_rd;

  pa_ram #(.DEPTH(NUM_PAGES), .WIDTH(CW + 1)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd),
    .re_i(c_re), .raddr_i(c_ra), .rdata_o(c_rd)
  );
  pa_ram #(.DEPTH(NUM_PAGES), .WIDTH(MW)) u_next (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd),
    .re_i(n_re), .raddr_i(n_ra), .rdata_o(n_rd)
  );
  pa_ram #(.DEPTH(NUM_PAGES), .WIDTH(MW)) u_prev (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .re_i(p_re), .raddr_i(p_ra), .rdata_o(p_rd)
  );

  logic in_acc, out_acc, cfg_acc;
  assign in_stall_o  = (state_q != pa_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  logic [31:0] push_sum;
  logic        page_ok;
  logic [CW-1:0] cnt_dec;
  assign push_sum = 32'(bottom_q) + 32'(page_count_i);
  assign page_ok  = 32'(page_number_i) < 32'(NUM_PAGES);
  assign cnt_dec  = c_rd[CW-1:0] - CW'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    top_d = top_q; bottom_d = bottom_q; head_d = head_q;
    idx_d = idx_q; end_d = end_q; mode_d = mode_q; page_d = page_q;
    res_page_d = res_page_q; res_st_d = res_st_q;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_re = 1'b0; c_ra = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0; n_re = 1'b0; n_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0; p_re = 1'b0; p_ra = '0;
    case (state_q)
      pa_pkg::S_CLR: begin
        c_we = 1'b1;
        c_wa = PW'(idx_q);
        c_wd = {1'b0, CW'(idx_q < bottom_q)};
        idx_d = idx_q + MW'(1);
        if (idx_q == LAST_M) begin
          state_d = pa_pkg::S_IDLE;
        end
      end
      pa_pkg::S_IDLE: begin
        if (in_acc) begin
          mode_d     = pa_pkg::mode_e'(mode_i);
          page_d     = PW'(page_number_i);
          res_page_d = '0;
          res_st_d   = pa_pkg::ST_OK;
          state_d    = pa_pkg::S_OUT;
          case (pa_pkg::mode_e'(mode_i))
            pa_pkg::MODE_ALLOC: begin
              if (head_q != NO_LINK) begin
                c_re = 1'b1; c_ra = PW'(head_q);
                n_re = 1'b1; n_ra = PW'(head_q);
                state_d = pa_pkg::S_ALLOC;
              end else if (bottom_q < top_q) begin
                top_d      = top_q - MW'(1);
                res_page_d = top_q - MW'(1);
              end else begin
                res_st_d = pa_pkg::ST_OOM;
              end
            end
            pa_pkg::MODE_PUSH: begin
              res_page_d = bottom_q;
              if (push_sum > 32'(top_q)) begin
                res_st_d = pa_pkg::ST_OOM;
              end else if (page_count_i != '0) begin
                idx_d   = bottom_q;
                end_d   = MW'(push_sum);
                state_d = pa_pkg::S_PUSH;
              end
            end
            default: begin
              if (page_ok) begin
                c_re = 1'b1; c_ra = PW'(page_number_i);
                state_d = pa_pkg::S_RMW;
              end
            end
          endcase
        end
      end
      pa_pkg::S_ALLOC: begin
        // unlink the head page
        res_page_d = head_q;
        c_we = 1'b1; c_wa = PW'(head_q); c_wd = {1'b0, c_rd[CW-1:0]};
        if (n_rd != NO_LINK) begin
          p_we = 1'b1; p_wa = PW'(n_rd); p_wd = NO_LINK;
        end
        head_d  = n_rd;
        state_d = pa_pkg::S_OUT;
      end
      pa_pkg::S_PUSH: begin
        c_we = 1'b1; c_wa = PW'(idx_q); c_wd = {1'b0, CW'(1)};
        idx_d = idx_q + MW'(1);
        if (idx_q + MW'(1) == end_q) begin
          bottom_d = end_q;
          state_d  = pa_pkg::S_OUT;
        end
      end
      pa_pkg::S_RMW: begin
        state_d = pa_pkg::S_OUT;
        c_wa = page_q;
        if (mode_q == pa_pkg::MODE_INC) begin
          if (c_rd[CW-1:0] == CMAX) begin
            res_st_d = pa_pkg::ST_SAT;
          end else begin
            c_we = 1'b1; c_wd = {c_rd[CW], c_rd[CW-1:0] + CW'(1)};
          end
        end else if (c_rd[CW-1:0] == '0) begin
          res_st_d = pa_pkg::ST_ZERO;
        end else begin
          c_we = 1'b1; c_wd = {c_rd[CW], cnt_dec};
          if (cnt_dec == '0) begin
            if (MW'(page_q) == top_q && top_q < limit_q) begin
              top_d   = top_q + MW'(1);
              state_d = pa_pkg::S_WRD;
            end else if (MW'(page_q) > top_q && MW'(page_q) < limit_q && !c_rd[CW]) begin
              // link at the head of the free list
              c_wd = {1'b1, CW'(0)};
              n_we = 1'b1; n_wa = page_q; n_wd = head_q;
              p_we = 1'b1; p_wa = page_q; p_wd = NO_LINK;
              state_d = pa_pkg::S_LINK;
            end
          end
        end
      end
      pa_pkg::S_LINK: begin
        if (head_q != NO_LINK) begin
          p_we = 1'b1; p_wa = PW'(head_q); p_wd = MW'(page_q);
        end
        head_d  = MW'(page_q);
        state_d = pa_pkg::S_OUT;
      end
      pa_pkg::S_WRD: begin
        if (top_q < limit_q) begin
          c_re = 1'b1; c_ra = PW'(top_q);
          n_re = 1'b1; n_ra = PW'(top_q);
          p_re = 1'b1; p_ra = PW'(top_q);
          state_d = pa_pkg::S_WCHK;
        end else begin
          state_d = pa_pkg::S_OUT;
        end
      end
      pa_pkg::S_WCHK: begin
        // climb over a zero-count page, unlinking it if listed
        if (c_rd[CW-1:0] == '0) begin
          if (c_rd[CW]) begin
            c_we = 1'b1; c_wa = PW'(top_q); c_wd = '0;
            if (p_rd != NO_LINK) begin
              n_we = 1'b1; n_wa = PW'(p_rd); n_wd = n_rd;
            end else begin
              head_d = n_rd;
            end
            if (n_rd != NO_LINK) begin
              p_we = 1'b1; p_wa = PW'(n_rd); p_wd = p_rd;
            end
          end
          top_d   = top_q + MW'(1);
          state_d = pa_pkg::S_WRD;
        end else begin
          state_d = pa_pkg::S_OUT;
        end
      end
      pa_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = pa_pkg::S_IDLE;
        end
      end
      default: state_d = pa_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pa_pkg::S_CLR;
      total_q  <= pa_pkg::TOTAL_RST;
      first_q  <= pa_pkg::FIRST_RST;
      limit_q  <= clamp(pa_pkg::TOTAL_RST);
      top_q    <= clamp(pa_pkg::TOTAL_RST);
      bottom_q <= clamp(pa_pkg::FIRST_RST);
      head_q   <= NO_LINK;
      idx_q    <= '0;
    end else if (cfg_acc) begin
      if (pa_pkg::reg_e'(cfg_index_i) == pa_pkg::REG_TOTAL) begin
        total_q  <= cfg_data_i;
        limit_q  <= clamp(cfg_data_i);
        top_q    <= clamp(cfg_data_i);
        bottom_q <= clamp(first_q);
      end else begin
        first_q  <= cfg_data_i;
        limit_q  <= clamp(total_q);
        top_q    <= clamp(total_q);
        bottom_q <= clamp(cfg_data_i);
      end
      head_q  <= NO_LINK;
      idx_q   <= '0;
      state_q <= pa_pkg::S_CLR;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      bottom_q <= bottom_d;
      head_q   <= head_d;
      idx_q    <= idx_d;
    end
  end

  // request payload and pending result
  always_ff @(posedge clk_i) begin
    end_q      <= end_d;
    mode_q     <= mode_d;
    page_q     <= page_d;
    res_page_q <= res_page_d;
    res_st_q   <= res_st_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == pa_pkg::S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pa_pkg::S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_page_q <= pa_pkg::PAGE_W'(res_page_q);
      out_st_q   <= res_st_q;
      out_free_q <= (top_q > bottom_q) ? pa_pkg::COUNT_W'(top_q - bottom_q) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_page_o = out_page_q;
  assign status_o      = out_st_q;
  assign free_pages_o  = out_free_q;

  // checks
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q != NO_LINK |-> head_q < limit_q)
    else $error("free list head outside the managed range");
  a_top_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= limit_q)
    else $error("top mark above the limit");
  a_push_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pa_pkg::S_PUSH |-> idx_q < end_q)
    else $error("push carve index past its end");

endmodule

### hdl/pa_ram.sv
// simple dual port ram with registered read
module pa_ram #(
  parameter int unsigned DEPTH = pa_pkg::NUM_PAGES_DEF,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
